// ----- design/amp_pkg.sv -----
// Shared types, constants and helpers of the metablock parser.
`timescale 1ns / 1ps

package amp_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int SIZE_BITS   = 30;
	localparam int LIMIT_BITS  = 16;

	localparam logic [5:0] MAX_QP       = 6'd51;
	localparam logic [7:0] QUALITY_CEIL = 8'd100;

	// Configuration register indexes
	localparam logic CFG_AVC444_MODE  = 1'b0;
	localparam logic CFG_REGION_LIMIT = 1'b1;

	// Error codes
	localparam logic [7:0] ERR_TRUNCATED     = 8'd0;
	localparam logic [7:0] ERR_REGION_LIMIT  = 8'd1;
	localparam logic [7:0] ERR_REGION_SPACE  = 8'd2;
	localparam logic [7:0] ERR_EMPTY_RECT    = 8'd3;
	localparam logic [7:0] ERR_QP_RANGE      = 8'd4;
	localparam logic [7:0] ERR_QUALITY_RANGE = 8'd5;
	localparam logic [7:0] ERR_NO_PAYLOAD    = 8'd6;
	localparam logic [7:0] ERR_SIZE_OVERRUN  = 8'd7;
	localparam logic [7:0] ERR_SIZE_MISMATCH = 8'd8;
	localparam logic [7:0] ERR_BAD_LAYOUT    = 8'd9;

	localparam logic [1:0] LAYOUT_DUAL = 2'd0;
	localparam logic [1:0] LAYOUT_LUMA = 2'd1;
	localparam logic [1:0] LAYOUT_AUX  = 2'd2;
	localparam logic [1:0] LAYOUT_BAD  = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_INFO,
		PH_COUNT,
		PH_RECT,
		PH_QP,
		PH_QUAL,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [2:0] {
		KIND_RECT    = 3'd0,
		KIND_QUANT   = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_LAYOUT  = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef struct packed {
		logic                  avc444_mode;
		logic [LIMIT_BITS-1:0] region_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic        substream;
		logic [15:0] region_index;
		logic [15:0] rect_left;
		logic [15:0] rect_top;
		logic [15:0] rect_right;
		logic [15:0] rect_bottom;
		logic [5:0]  quant_qp;
		logic        progressive_flag;
		logic [6:0]  quality;
		logic [7:0]  value;
	} res_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_status_t;

	function automatic res_t make_result(kind_t kind, logic sub, logic [7:0] val);
		res_t r;
		r = '0;
		r.kind = kind;
		r.substream = sub;
		r.value = val;
		return r;
	endfunction

endpackage

// ----- design/amp_step.sv -----
// Parse state and the combinational step that consumes one message byte.
`timescale 1ns / 1ps

module amp_step
	import amp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_message,
	input  logic [LENGTH_BITS-1:0] message_length,
	input  cfg_t                   cfg,
	output logic                   res_valid,
	output res_t                   res
);

	phase_t                 phase_q, e_phase, phase_n;
	logic [2:0]             pos_q, e_pos, pos_n;
	logic [7:0]             gather_q [7];
	logic [15:0]            total_q, total_n;
	logic [15:0]            counter_q, e_counter, counter_n;
	logic [LENGTH_BITS-1:0] blm_q, e_blm, blm_n;
	logic [LENGTH_BITS-1:0] bls_q, e_bls, bls_n;
	logic [7:0]             qp_q, qp_n;
	logic [1:0]             layout_q, e_layout, layout_n;
	logic                   sub_q, e_sub, sub_n;

	logic [LENGTH_BITS-1:0] len_eff, blm_dec, bls_dec, sub_len;
	logic                   sub_end;
	logic [31:0]            word;
	logic [SIZE_BITS-1:0]   size, rem_ext;
	logic [1:0]             layout;
	logic [19:0]            cnt10;
	logic [15:0]            l, t, r, bo, cnt_inc;

	always_comb begin
		len_eff = (message_length == '0) ? {{(LENGTH_BITS-1){1'b0}}, 1'b1} : message_length;

		// Start of a message overrides the held state
		e_phase   = phase_q;
		e_pos     = pos_q;
		e_counter = counter_q;
		e_blm     = blm_q;
		e_bls     = bls_q;
		e_layout  = layout_q;
		e_sub     = sub_q;
		if (first_of_message) begin
			e_phase   = cfg.avc444_mode ? PH_INFO : PH_COUNT;
			e_pos     = 3'd0;
			e_counter = '0;
			e_blm     = len_eff;
			e_bls     = len_eff;
			e_layout  = cfg.avc444_mode ? LAYOUT_DUAL : LAYOUT_LUMA;
			e_sub     = 1'b0;
		end

		phase_n   = e_phase;
		pos_n     = e_pos;
		total_n   = total_q;
		counter_n = e_counter;
		blm_n     = e_blm;
		bls_n     = e_bls;
		qp_n      = qp_q;
		layout_n  = e_layout;
		sub_n     = e_sub;
		res_valid = 1'b0;
		res       = '0;

		blm_dec = e_blm - 1'b1;
		bls_dec = e_bls - 1'b1;
		sub_end = (bls_dec == '0);
		word    = {data_byte, gather_q[2], gather_q[1], gather_q[0]};
		size    = word[SIZE_BITS-1:0];
		layout  = word[31:30];
		rem_ext = {{(SIZE_BITS-LENGTH_BITS){1'b0}}, blm_dec};
		cnt10   = ({4'd0, word[15:0]} << 3) + ({4'd0, word[15:0]} << 1);
		l       = {gather_q[1], gather_q[0]};
		t       = {gather_q[3], gather_q[2]};
		r       = {gather_q[5], gather_q[4]};
		bo      = {data_byte, gather_q[6]};
		cnt_inc = e_counter + 16'd1;
		sub_len = (layout == LAYOUT_DUAL) ? size[LENGTH_BITS-1:0] : blm_dec;

		if (e_phase == PH_IDLE) begin
			phase_n = PH_IDLE;
		end else if (e_blm == '0) begin
			phase_n = PH_IDLE;
		end else begin
			blm_n = blm_dec;
			if (e_phase == PH_INFO) begin
				pos_n = e_pos + 3'd1;
				if (e_pos != 3'd3) begin
					if (blm_dec == '0) begin
						phase_n   = PH_IDLE;
						res_valid = 1'b1;
						res       = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
					end
				end else begin
					res_valid = 1'b1;
					phase_n   = PH_IDLE;
					if (layout == LAYOUT_BAD) begin
						res = make_result(KIND_ERROR, e_sub, ERR_BAD_LAYOUT);
					end else if (layout == LAYOUT_DUAL && size > rem_ext) begin
						res = make_result(KIND_ERROR, e_sub, ERR_SIZE_OVERRUN);
					end else if (layout == LAYOUT_LUMA && size != rem_ext) begin
						res = make_result(KIND_ERROR, e_sub, ERR_SIZE_MISMATCH);
					end else if (layout == LAYOUT_AUX && size != '0 && size != rem_ext) begin
						res = make_result(KIND_ERROR, e_sub, ERR_SIZE_MISMATCH);
					end else if (sub_len == '0) begin
						res = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
					end else begin
						layout_n = layout;
						bls_n    = sub_len;
						pos_n    = 3'd0;
						phase_n  = PH_COUNT;
						res      = make_result(KIND_LAYOUT, e_sub, {6'd0, layout});
					end
				end
			end else if (e_bls == '0) begin
				phase_n = PH_IDLE;
			end else begin
				bls_n = bls_dec;
				case (e_phase)
					PH_COUNT: begin
						pos_n = e_pos + 3'd1;
						if (e_pos != 3'd3) begin
							if (sub_end) begin
								phase_n   = PH_IDLE;
								res_valid = 1'b1;
								res       = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
							end
						end else if (word[31:16] != '0 || word[15:0] > cfg.region_limit) begin
							phase_n   = PH_IDLE;
							res_valid = 1'b1;
							res       = make_result(KIND_ERROR, e_sub, ERR_REGION_LIMIT);
						end else if ({4'd0, cnt10} > bls_dec) begin
							phase_n   = PH_IDLE;
							res_valid = 1'b1;
							res       = make_result(KIND_ERROR, e_sub, ERR_REGION_SPACE);
						end else begin
							counter_n = '0;
							pos_n     = 3'd0;
							total_n   = word[15:0];
							if (word[15:0] != '0) begin
								phase_n = PH_RECT;
							end else if (sub_end) begin
								phase_n   = PH_IDLE;
								res_valid = 1'b1;
								res       = make_result(KIND_ERROR, e_sub, ERR_NO_PAYLOAD);
							end else begin
								phase_n = PH_PAYLOAD;
							end
						end
					end
					PH_RECT: begin
						pos_n = e_pos + 3'd1;
						if (e_pos != 3'd7) begin
							if (sub_end) begin
								phase_n   = PH_IDLE;
								res_valid = 1'b1;
								res       = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
							end
						end else if (l >= r || t >= bo) begin
							phase_n   = PH_IDLE;
							res_valid = 1'b1;
							res       = make_result(KIND_ERROR, e_sub, ERR_EMPTY_RECT);
						end else if (sub_end) begin
							phase_n   = PH_IDLE;
							res_valid = 1'b1;
							res       = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
						end else begin
							res_valid        = 1'b1;
							res              = make_result(KIND_RECT, e_sub, 8'd0);
							res.region_index = e_counter;
							res.rect_left    = l;
							res.rect_top     = t;
							res.rect_right   = r;
							res.rect_bottom  = bo;
							pos_n            = 3'd0;
							counter_n        = cnt_inc;
							if (cnt_inc == total_q) begin
								counter_n = '0;
								phase_n   = PH_QP;
							end
						end
					end
					PH_QP: begin
						qp_n    = data_byte;
						phase_n = PH_QUAL;
						if (sub_end) begin
							phase_n   = PH_IDLE;
							res_valid = 1'b1;
							res       = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
						end
					end
					PH_QUAL: begin
						res_valid = 1'b1;
						if (qp_q[5:0] > MAX_QP) begin
							phase_n = PH_IDLE;
							res     = make_result(KIND_ERROR, e_sub, ERR_QP_RANGE);
						end else if (data_byte > QUALITY_CEIL) begin
							phase_n = PH_IDLE;
							res     = make_result(KIND_ERROR, e_sub, ERR_QUALITY_RANGE);
						end else if (sub_end) begin
							phase_n = PH_IDLE;
							res     = make_result(KIND_ERROR, e_sub, ERR_NO_PAYLOAD);
						end else begin
							res                  = make_result(KIND_QUANT, e_sub, 8'd0);
							res.region_index     = e_counter;
							res.quant_qp         = qp_q[5:0];
							res.progressive_flag = qp_q[7];
							res.quality          = data_byte[6:0];
							counter_n            = cnt_inc;
							phase_n              = (cnt_inc == total_q) ? PH_PAYLOAD : PH_QP;
						end
					end
					PH_PAYLOAD: begin
						res_valid = 1'b1;
						res       = make_result(KIND_PAYLOAD, e_sub, data_byte);
						if (sub_end) begin
							if (e_layout == LAYOUT_DUAL && !e_sub) begin
								if (blm_dec == '0) begin
									phase_n = PH_IDLE;
									res     = make_result(KIND_ERROR, e_sub, ERR_TRUNCATED);
								end else begin
									sub_n   = 1'b1;
									bls_n   = blm_dec;
									pos_n   = 3'd0;
									phase_n = PH_COUNT;
								end
							end else begin
								phase_n = PH_IDLE;
							end
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= 3'd0;
			total_q   <= '0;
			counter_q <= '0;
			blm_q     <= '0;
			bls_q     <= '0;
			qp_q      <= '0;
			layout_q  <= '0;
			sub_q     <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			total_q   <= total_n;
			counter_q <= counter_n;
			blm_q     <= blm_n;
			bls_q     <= bls_n;
			qp_q      <= qp_n;
			layout_q  <= layout_n;
			sub_q     <= sub_n;
		end
	end

	// Field bytes land in their lane; the last byte of a field is used straight from the input
	always_ff @(posedge clk) begin
		if (accept && e_pos != 3'd7) begin
			gather_q[e_pos] <= data_byte;
		end
	end

endmodule

// ----- design/amp_out_buf.sv -----
// Result register with one skid entry behind it.
`timescale 1ns / 1ps

module amp_out_buf
	import amp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  res_t        push_data,
	input  logic        pop_stall,
	output logic        pop_valid,
	output res_t        pop_data,
	output buf_status_t status
);

	logic out_v_q, skid_v_q, out_v_n, skid_v_n;
	res_t out_q, skid_q;
	logic drain, load_from_skid, load_from_in, load_skid;

	always_comb begin
		drain          = out_v_q && !pop_stall;
		load_from_skid = skid_v_q && drain;
		load_from_in   = !skid_v_q && push && (!out_v_q || drain);
		load_skid      = !skid_v_q && push && out_v_q && !drain;
		out_v_n        = out_v_q;
		skid_v_n       = skid_v_q;
		if (load_from_skid) begin
			skid_v_n = 1'b0;
		end else if (load_from_in || load_skid) begin
			out_v_n  = 1'b1;
			skid_v_n = load_skid;
		end else if (drain) begin
			out_v_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q  <= out_v_n;
			skid_v_q <= skid_v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_q <= skid_q;
		end else if (load_from_in) begin
			out_q <= push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

	assign pop_valid        = out_v_q;
	assign pop_data         = out_q;
	assign status.out_full  = out_v_q;
	assign status.skid_full = skid_v_q;

endmodule

// ----- design/avc_metablock_parser.sv -----
// Top level of the AVC420/AVC444 metablock parser.
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// item      item_valid / item_stall     data_byte, first_of_message, message_length
// result    result_valid / result_stall result_kind .. value (one item per result)
// config    wr_en                       wr_index, wr_data
//
// One byte is parsed per cycle while item_stall is low; the parse step is pure
// logic between parse state and result registers, so items flow back to back.
// Results wait in an output register plus one skid entry; item_stall rises only
// while the skid entry holds a result, and drops as soon as the output drains.
// Reset (arst_n low) returns the parser to idle, empties both result entries and
// loads avc444_mode = 0, region_limit = 1024. No clearing pass is needed.

module avc_metablock_parser
	import amp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// item channel
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_message,
	input  logic [LENGTH_BITS-1:0] message_length,
	// result channel
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [2:0]             result_kind,
	output logic                   substream,
	output logic [15:0]            region_index,
	output logic [15:0]            rect_left,
	output logic [15:0]            rect_top,
	output logic [15:0]            rect_right,
	output logic [15:0]            rect_bottom,
	output logic [5:0]             quant_qp,
	output logic                   progressive_flag,
	output logic [6:0]             quality,
	output logic [7:0]             value,
	// configuration write port
	input  logic                   wr_en,
	input  logic                   wr_index,
	input  logic [LIMIT_BITS-1:0]  wr_data
);

	cfg_t        cfg_q;
	logic        accept;
	logic        step_valid;
	res_t        step_res;
	res_t        out_res;
	buf_status_t buf_status;

	// Configuration registers: user writes only while the parser is idle, unenforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avc444_mode  <= 1'b0;
			cfg_q.region_limit <= 16'd1024;
		end else if (wr_en) begin
			case (wr_index)
				CFG_AVC444_MODE:  cfg_q.avc444_mode  <= wr_data[0];
				CFG_REGION_LIMIT: cfg_q.region_limit <= wr_data;
				default: ;
			endcase
		end
	end

	// Take an item whenever the skid entry is free
	assign item_stall = buf_status.skid_full;
	assign accept     = item_valid && !item_stall;

	amp_step u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.message_length   (message_length),
		.cfg              (cfg_q),
		.res_valid        (step_valid),
		.res              (step_res)
	);

	// Push only results of accepted items; drop the rest
	amp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && step_valid),
		.push_data (step_res),
		.pop_stall (result_stall),
		.pop_valid (result_valid),
		.pop_data  (out_res),
		.status    (buf_status)
	);

	assign result_kind      = out_res.kind;
	assign substream        = out_res.substream;
	assign region_index     = out_res.region_index;
	assign rect_left        = out_res.rect_left;
	assign rect_top         = out_res.rect_top;
	assign rect_right       = out_res.rect_right;
	assign rect_bottom      = out_res.rect_bottom;
	assign quant_qp         = out_res.quant_qp;
	assign progressive_flag = out_res.progressive_flag;
	assign quality          = out_res.quality;
	assign value            = out_res.value;

	// A stalled input means both result entries are occupied
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stall without a pending result");

	// The skid entry empties as soon as the output drains
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(item_stall && !result_stall) |=> !item_stall)
		else $error("skid entry held after output drained");

	// Rectangles reaching the output are never empty
	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_RECT) |->
		(rect_left < rect_right && rect_top < rect_bottom))
		else $error("empty rectangle delivered");

	// Quant values reaching the output are in range
	a_quant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_QUANT) |->
		(quant_qp <= MAX_QP && {1'b0, quality} <= QUALITY_CEIL))
		else $error("quant values out of range delivered");

endmodule

// ----- verif/metablock_checker.sv -----
// Result checker of the metablock parser: predicts each result and compares it.
`timescale 1ns / 1ps

module metablock_checker
	import amp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_message,
	input  logic [LENGTH_BITS-1:0] message_length,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [2:0]             result_kind,
	input  logic                   substream,
	input  logic [15:0]            region_index,
	input  logic [15:0]            rect_left,
	input  logic [15:0]            rect_top,
	input  logic [15:0]            rect_right,
	input  logic [15:0]            rect_bottom,
	input  logic [5:0]             quant_qp,
	input  logic                   progressive_flag,
	input  logic [6:0]             quality,
	input  logic [7:0]             value,
	input  logic                   wr_en,
	input  logic                   wr_index,
	input  logic [LIMIT_BITS-1:0]  wr_data,
	output int                     fail_count,
	output int                     pending
);

	localparam int RECORD_BYTES = 8 + 2;

	logic                   mode_444;
	logic [LIMIT_BITS-1:0]  region_cap;
	phase_t                 parse_phase;
	logic [3:0]             field_pos;
	logic [63:0]            gather;
	logic [31:0]            count_total;
	logic [15:0]            region_idx;
	logic [LENGTH_BITS-1:0] msg_left;
	logic [31:0]            sub_left;
	logic [7:0]             qp_hold;
	logic [1:0]             layout_hold;
	logic                   cur_sub;
	res_t                   predicted_results[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic res_t blank_result(kind_t kind, logic [7:0] val);
		res_t res;
		res = '0;
		res.kind = kind;
		res.substream = cur_sub;
		res.value = val;
		return res;
	endfunction

	// An error reports its code and drops the rest of the message.
	task automatic abort(logic [7:0] code);
		parse_phase = PH_IDLE;
		predicted_results.push_back(blank_result(KIND_ERROR, code));
	endtask

	task automatic parse_byte(logic [7:0] b, logic first, logic [LENGTH_BITS-1:0] len);
		logic [29:0] size;
		logic [1:0]  layout;
		logic [31:0] sub;
		logic [15:0] l, t, r, bo;
		logic        at_end;
		res_t        res;
		if (first) begin
			msg_left = (len == 0) ? LENGTH_BITS'(1) : len;
			sub_left = 32'(msg_left);
			field_pos = '0;
			gather = '0;
			cur_sub = 1'b0;
			count_total = '0;
			region_idx = '0;
			qp_hold = '0;
			layout_hold = mode_444 ? LAYOUT_DUAL : LAYOUT_LUMA;
			parse_phase = mode_444 ? PH_INFO : PH_COUNT;
		end
		if (parse_phase == PH_IDLE) return;
		if (msg_left == 0) begin
			parse_phase = PH_IDLE;
			return;
		end
		msg_left--;

		if (parse_phase == PH_INFO) begin
			gather |= {56'd0, b} << (8 * field_pos[1:0]);
			field_pos++;
			if (field_pos < 4) begin
				if (msg_left == 0) abort(ERR_TRUNCATED);
				return;
			end
			size = gather[29:0];
			layout = gather[31:30];
			if (layout == LAYOUT_BAD) begin
				abort(ERR_BAD_LAYOUT);
				return;
			end
			if (layout == LAYOUT_DUAL) begin
				if (size > msg_left) begin
					abort(ERR_SIZE_OVERRUN);
					return;
				end
				sub = 32'(size);
			end else begin
				// aux-only also accepts a zero size
				if (size != msg_left && !(layout == LAYOUT_AUX && size == 0)) begin
					abort(ERR_SIZE_MISMATCH);
					return;
				end
				sub = 32'(msg_left);
			end
			if (sub == 0) begin
				abort(ERR_TRUNCATED);
				return;
			end
			layout_hold = layout;
			sub_left = sub;
			field_pos = '0;
			gather = '0;
			parse_phase = PH_COUNT;
			predicted_results.push_back(blank_result(KIND_LAYOUT, {6'd0, layout}));
			return;
		end

		if (sub_left == 0) begin
			parse_phase = PH_IDLE;
			return;
		end
		sub_left--;
		at_end = (sub_left == 0);

		case (parse_phase)
			PH_COUNT: begin
				gather |= {56'd0, b} << (8 * field_pos[1:0]);
				field_pos++;
				if (field_pos < 4) begin
					if (at_end) abort(ERR_TRUNCATED);
					return;
				end
				count_total = gather[31:0];
				if (count_total > region_cap) abort(ERR_REGION_LIMIT);
				else if (64'(count_total) * RECORD_BYTES > 64'(sub_left)) abort(ERR_REGION_SPACE);
				else begin
					region_idx = '0;
					field_pos = '0;
					gather = '0;
					if (count_total != 0) parse_phase = PH_RECT;
					else if (at_end) abort(ERR_NO_PAYLOAD);
					else parse_phase = PH_PAYLOAD;
				end
			end
			PH_RECT: begin
				gather |= {56'd0, b} << (8 * field_pos[2:0]);
				field_pos++;
				if (field_pos < 8) begin
					if (at_end) abort(ERR_TRUNCATED);
					return;
				end
				{bo, r, t, l} = gather;
				if (l >= r || t >= bo) abort(ERR_EMPTY_RECT);
				else if (at_end) abort(ERR_TRUNCATED);
				else begin
					res = blank_result(KIND_RECT, 8'd0);
					res.region_index = region_idx;
					res.rect_left = l;
					res.rect_top = t;
					res.rect_right = r;
					res.rect_bottom = bo;
					predicted_results.push_back(res);
					region_idx++;
					field_pos = '0;
					gather = '0;
					if (region_idx == count_total[15:0]) begin
						region_idx = '0;
						parse_phase = PH_QP;
					end
				end
			end
			PH_QP: begin
				qp_hold = b;
				parse_phase = PH_QUAL;
				if (at_end) abort(ERR_TRUNCATED);
			end
			PH_QUAL: begin
				if (qp_hold[5:0] > MAX_QP) abort(ERR_QP_RANGE);
				else if (b > QUALITY_CEIL) abort(ERR_QUALITY_RANGE);
				else if (at_end) abort(ERR_NO_PAYLOAD);
				else begin
					res = blank_result(KIND_QUANT, 8'd0);
					res.region_index = region_idx;
					res.quant_qp = qp_hold[5:0];
					res.progressive_flag = qp_hold[7];
					res.quality = b[6:0];
					predicted_results.push_back(res);
					region_idx++;
					parse_phase = (region_idx == count_total[15:0]) ? PH_PAYLOAD : PH_QP;
				end
			end
			PH_PAYLOAD: begin
				if (!at_end) predicted_results.push_back(blank_result(KIND_PAYLOAD, b));
				else if (layout_hold == LAYOUT_DUAL && !cur_sub) begin
					// first of two substreams: the second takes the rest of the message
					if (msg_left == 0) abort(ERR_TRUNCATED);
					else begin
						predicted_results.push_back(blank_result(KIND_PAYLOAD, b));
						cur_sub = 1'b1;
						sub_left = 32'(msg_left);
						field_pos = '0;
						gather = '0;
						parse_phase = PH_COUNT;
					end
				end else begin
					parse_phase = PH_IDLE;
					predicted_results.push_back(blank_result(KIND_PAYLOAD, b));
				end
			end
			default: parse_phase = PH_IDLE;
		endcase
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (predicted_results.size() == 0) begin
			$error("result of kind %0d arrived with none predicted", result_kind);
			fail_count++;
			return;
		end
		want = predicted_results.pop_front();
		compare_field("result_kind", 16'(want.kind), 16'(result_kind));
		compare_field("substream", 16'(want.substream), 16'(substream));
		compare_field("region_index", want.region_index, region_index);
		compare_field("rect_left", want.rect_left, rect_left);
		compare_field("rect_top", want.rect_top, rect_top);
		compare_field("rect_right", want.rect_right, rect_right);
		compare_field("rect_bottom", want.rect_bottom, rect_bottom);
		compare_field("quant_qp", 16'(want.quant_qp), 16'(quant_qp));
		compare_field("progressive_flag", 16'(want.progressive_flag), 16'(progressive_flag));
		compare_field("quality", 16'(want.quality), 16'(quality));
		compare_field("value", 16'(want.value), 16'(value));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_444 = 1'b0;
			region_cap = LIMIT_BITS'(1024);
			parse_phase = PH_IDLE;
			field_pos = '0;
			gather = '0;
			count_total = '0;
			region_idx = '0;
			msg_left = '0;
			sub_left = '0;
			qp_hold = '0;
			layout_hold = '0;
			cur_sub = 1'b0;
			predicted_results.delete();
			pending <= 0;
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_AVC444_MODE) mode_444 = wr_data[0];
				else region_cap = wr_data;
			end
			if (item_valid && !item_stall)
				parse_byte(data_byte, first_of_message, message_length);
			if (result_valid && !result_stall) check_result();
			pending <= predicted_results.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the metablock parser testbench: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module testbench
	import amp_pkg::*;
();

	// Kinds of damage that a random substream may carry
	typedef enum int {
		FAULT_NONE,
		FAULT_RECT,
		FAULT_QP,
		FAULT_QUALITY,
		FAULT_COUNT
	} fault_t;

	localparam int SEGMENT_ITEMS = 100;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic [7:0]             data_byte = '0;
	logic                   first_of_message = 1'b0;
	logic [LENGTH_BITS-1:0] message_length = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [2:0]             result_kind;
	logic                   substream;
	logic [15:0]            region_index;
	logic [15:0]            rect_left;
	logic [15:0]            rect_top;
	logic [15:0]            rect_right;
	logic [15:0]            rect_bottom;
	logic [5:0]             quant_qp;
	logic                   progressive_flag;
	logic [6:0]             quality;
	logic [7:0]             value;
	logic                   wr_en = 1'b0;
	logic                   wr_index = 1'b0;
	logic [LIMIT_BITS-1:0]  wr_data = '0;
	int                     fail_count;
	int                     pending;

	int                     idle_pct = 8;
	int                     stall_pct = 54;
	int                     items_sent = 0;
	logic                   mode_now = 1'b0;
	logic [7:0]             msg_q[$];

	avc_metablock_parser u_top (.*);
	metablock_checker u_check (.*);

	always #4 clk = ~clk;

	// The receiver stalls at random, at the rate of the current pacing phase.
	always @(posedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	// Hard stop in case the parser hangs or a result never shows up.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one item, idling first at the sender's rate; hold it until taken.
	// Valid stays high after acceptance so that back-to-back items never toggle it.
	task automatic send_item(logic [7:0] b, logic first, logic [LENGTH_BITS-1:0] len);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= b;
		first_of_message <= first;
		message_length <= len;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// Send the assembled message; the length field only counts on the first byte,
	// so fill it with noise elsewhere.
	task automatic send_message(logic [LENGTH_BITS-1:0] declared);
		for (int i = 0; i < msg_q.size(); i++)
			send_item(msg_q[i], i == 0, (i == 0) ? declared : LENGTH_BITS'($urandom));
		msg_q.delete();
	endtask

	// Drop valid, wait for every predicted result, then let the pipe settle.
	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
	endtask

	// Write both registers back to back; only called with the parser quiet.
	task automatic configure(logic mode, logic [LIMIT_BITS-1:0] cap);
		wr_en <= 1'b1;
		wr_index <= CFG_AVC444_MODE;
		wr_data <= LIMIT_BITS'(mode);
		@(posedge clk);
		wr_index <= CFG_REGION_LIMIT;
		wr_data <= cap;
		@(posedge clk);
		wr_en <= 1'b0;
		mode_now = mode;
	endtask

	function automatic void put_le(logic [63:0] v, int n);
		for (int i = 0; i < n; i++) msg_q.push_back(v[8*i +: 8]);
	endfunction

	// Append one AVC420 substream: count, rectangles, quant pairs, payload.
	// A fault damages one randomly chosen region, or the count itself.
	function automatic void put_substream(int regions, int payload, fault_t fault);
		logic [15:0] l, t, r, bo;
		logic [5:0]  qp;
		logic [7:0]  grade;
		int          bad;
		bad = (regions > 0) ? $urandom_range(regions - 1) : 0;
		if (fault == FAULT_COUNT) put_le(64'($urandom), 4);
		else put_le(64'(regions), 4);
		for (int i = 0; i < regions; i++) begin
			l = 16'($urandom_range(16'hFFFE));
			r = 16'($urandom_range(16'hFFFF, l + 1));
			t = 16'($urandom_range(16'hFFFE));
			bo = 16'($urandom_range(16'hFFFF, t + 1));
			if (fault == FAULT_RECT && i == bad) begin
				if ($urandom_range(1)) r = 16'($urandom_range(l));
				else bo = 16'($urandom_range(t));
			end
			put_le({bo, r, t, l}, 8);
		end
		for (int i = 0; i < regions; i++) begin
			qp = 6'((fault == FAULT_QP && i == bad) ?
				$urandom_range(63, 52) : $urandom_range(51));
			grade = 8'((fault == FAULT_QUALITY && i == bad) ?
				$urandom_range(255, 101) : $urandom_range(100));
			// qp byte: progressive bit on top, an unused bit, then the qp itself
			put_le(64'({grade, 1'($urandom), 1'($urandom), qp}), 2);
		end
		for (int i = 0; i < payload; i++) msg_q.push_back(8'($urandom));
	endfunction

	// Mostly well-formed messages with random content; the rest carry a damaged
	// field, a wrong layout size or a wrong message length.
	task automatic random_message();
		int                     regions;
		int                     head;
		int                     rest;
		fault_t                 fault;
		logic [1:0]             layout;
		logic [29:0]            size;
		logic [31:0]            info;
		logic [LENGTH_BITS-1:0] declared;
		regions = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
		fault = ($urandom_range(9) == 0) ?
			fault_t'($urandom_range(FAULT_COUNT, FAULT_RECT)) : FAULT_NONE;
		if (!mode_now) put_substream(regions, $urandom_range(6), fault);
		else begin
			// reserve the info word, fill it once the substream sizes are known
			put_le(64'd0, 4);
			layout = ($urandom_range(15) == 0) ? LAYOUT_BAD : 2'($urandom_range(2));
			if ($urandom_range(19) != 0) put_substream(regions, $urandom_range(6), fault);
			head = msg_q.size() - 4;
			// now and then leave out the second substream so the first runs into the end
			if (layout == LAYOUT_DUAL && $urandom_range(7) != 0)
				put_substream($urandom_range(3), $urandom_range(6), FAULT_NONE);
			rest = msg_q.size() - 4;
			case (layout)
				LAYOUT_DUAL: size = 30'(head);
				LAYOUT_AUX:  size = $urandom_range(1) ? 30'(rest) : 30'd0;
				default:     size = 30'(rest);
			endcase
			if ($urandom_range(15) == 0) size = 30'($urandom);
			info = {layout, size};
			for (int i = 0; i < 4; i++) msg_q[i] = info[8*i +: 8];
		end
		declared = LENGTH_BITS'(msg_q.size());
		case ($urandom_range(19))
			0: declared = LENGTH_BITS'($urandom_range(msg_q.size()));
			1: declared = LENGTH_BITS'(msg_q.size() + $urandom_range(1, 5));
			2: declared = LENGTH_BITS'($urandom);
			default: ;
		endcase
		send_message(declared);
		// stray bytes with no first byte: ignored once the message is over
		if ($urandom_range(15) == 0)
			repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, LENGTH_BITS'($urandom));
	endtask

	initial begin
		logic [LIMIT_BITS-1:0] caps[6];
		int                    target;
		caps = '{16'hFFFF, 16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd1024};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed AVC420 cases
		configure(1'b0, 16'd1024);
		// zero length stands for one byte; the next byte finds nothing left
		send_item(8'h00, 1'b1, '0);
		send_item(8'hFF, 1'b0, '1);
		// widest rectangle, qp 51 with both upper bits set, quality 100
		put_le(64'd1, 4);
		put_le(64'hFFFF_FFFF_0000_0000, 8);
		put_le(64'h64F3, 2);
		put_le(64'h00FF, 2);
		send_message(LENGTH_BITS'(msg_q.size()));
		// last quant pair closes the substream: no payload left
		put_le(64'd1, 4);
		put_le(64'h0004_0003_0002_0001, 8);
		put_le(64'd0, 2);
		send_message(LENGTH_BITS'(msg_q.size()));
		// count far above the limit, then a byte that must be ignored
		put_le(64'hFFFF_FFFF, 4);
		send_message(LENGTH_BITS'(4));
		send_item(8'h5A, 1'b0, '0);
		// count within the limit but not within the bytes left
		put_le(64'd2, 4);
		put_le(64'd0, 3);
		send_message(LENGTH_BITS'(msg_q.size()));
		// empty rectangle, qp one past its limit, quality one past its limit
		put_le(64'd1, 4);
		put_le(64'h0002_0005_0001_0005, 8);
		put_le(64'h0000, 2);
		msg_q.push_back(8'h11);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'd1, 4);
		put_le(64'h0002_0006_0001_0005, 8);
		put_le(64'h0034, 2);
		msg_q.push_back(8'h11);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'd1, 4);
		put_le(64'h0002_0006_0001_0005, 8);
		put_le(64'h6500, 2);
		msg_q.push_back(8'h11);
		send_message(LENGTH_BITS'(msg_q.size()));
		// longest length, cut short by the first byte of the next message
		put_le(64'hAA_0000_0000, 5);
		send_message('1);

		// Directed AVC444 cases
		drain();
		configure(1'b1, 16'd1024);
		// two substreams of one payload byte each
		put_le(64'h0000_0005, 4);
		put_le(64'h3C_0000_0000, 5);
		put_le(64'hC3_0000_0000, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		// the first substream runs to the end of the message
		put_le(64'h0000_0005, 4);
		put_le(64'h3C_0000_0000, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		// luma-only with its exact size, aux-only with size zero
		put_le(64'h4000_0005, 4);
		put_le(64'h01_0000_0000, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'h8000_0000, 4);
		put_le(64'h02_0000_0000, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		// reserved layout, size mismatch, empty substream, size overrun
		put_le(64'hC000_0000, 4);
		put_le(64'd0, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'h4000_0009, 4);
		put_le(64'd0, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'h4000_0000, 4);
		send_message(LENGTH_BITS'(msg_q.size()));
		put_le(64'h3FFF_FFFF, 4);
		put_le(64'd0, 5);
		send_message(LENGTH_BITS'(msg_q.size()));
		// message ends inside the info word
		put_le(64'd0, 4);
		send_message(LENGTH_BITS'(2));

		// Random segments: alternate the mode, sweep the limit across its range,
		// and move from fast sender / busy receiver to the reverse to full rate.
		target = items_sent;
		for (int seg = 0; seg < 6; seg++) begin
			drain();
			case (seg / 2)
				0: begin
					idle_pct = 8;
					stall_pct = 54;
				end
				1: begin
					idle_pct = 54;
					stall_pct = 8;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			configure(1'(seg % 2), caps[seg]);
			target += SEGMENT_ITEMS;
			while (items_sent < target) random_message();
		end
		drain();

		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
design/amp_pkg.sv
design/amp_step.sv
design/amp_out_buf.sv
design/avc_metablock_parser.sv
verif/metablock_checker.sv
verif/testbench.sv
